// File: rtl/tiam_pkg.sv
// Shared widths, register indexes and structs of the image tile address mapper.
// No dependencies; imported by every module of the block.
package tiam_pkg;

  localparam int unsigned COORD_W = 12;  // pixel row / column
  localparam int unsigned DIM_W   = 13;  // image width / height register
  localparam int unsigned FAC_W   = 7;   // tile factor register
  localparam int unsigned PIX_W   = 16;  // gray value
  localparam int unsigned TILE_W  = 6;   // tile row / column outputs
  localparam int unsigned TIDX_W  = 12;  // raster tile index

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam int unsigned DEF_MAX_DIM    = 4096;
  localparam int unsigned DEF_MAX_FACTOR = 64;
  localparam int unsigned DEF_PIXEL_BITS = 16;

  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FACTOR = 2'd2;

  // per-axis constants derived from the configuration
  typedef struct packed {
    logic [DIM_W-1:0] span;   // ordinary tile size, dim / factor
    logic [DIM_W-1:0] base;   // start of the last tile, (factor - 1) * span
    logic             zero;   // span == 0
  } tiam_span_t;

  // word traveling through the divider pipeline
  typedef struct packed {
    logic               oor;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   val;
    logic [COORD_W-1:0] rq;   // row / row span, filled MSB first
    logic [COORD_W-1:0] cq;
    logic [COORD_W-1:0] rr;   // partial remainders
    logic [COORD_W-1:0] cr;
  } tiam_div_t;

endpackage

// File: rtl/tiam_span_div.sv
// Iterative divider computing one axis' tile span and last-tile base after a
// configuration write. Depends on tiam_pkg.
module tiam_span_div
  import tiam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIM_W-1:0] dim_i,
  input  logic [FAC_W-1:0] fac_i,
  output logic             busy_o,
  output tiam_span_t       span_o
);

  localparam int unsigned CNT_W = $clog2(DIM_W);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_MUL  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIM_W-1:0] num_q, num_d;
  logic [DIM_W-1:0] quo_q, quo_d;
  logic [FAC_W-1:0] rem_q, rem_d;
  tiam_span_t       span_q, span_d;
  logic [FAC_W:0]   shifted;
  logic [FAC_W:0]   diff;
  logic             take;

  // one quotient bit per cycle
  assign shifted = {rem_q, num_q[DIM_W-1]};
  assign take    = shifted >= {1'b0, fac_i};
  assign diff    = shifted - {1'b0, fac_i};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    span_d  = span_q;
    // a new write restarts the division from any state
    if (start_i) begin
      state_d = S_DIV;
      cnt_d   = '0;
      num_d   = dim_i;
      quo_d   = '0;
      rem_d   = '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
        end
        S_DIV: begin
          rem_d = take ? diff[FAC_W-1:0] : shifted[FAC_W-1:0];
          quo_d = {quo_q[DIM_W-2:0], take};
          num_d = {num_q[DIM_W-2:0], 1'b0};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIM_W - 1)) begin
            state_d = S_MUL;
          end
        end
        S_MUL: begin
          span_d.span = quo_q;
          span_d.base = DIM_W'((fac_i - 1'b1) * quo_q);
          span_d.zero = quo_q == '0;
          state_d     = S_IDLE;
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      span_q.span <= DIM_W'(1);
      span_q.base <= '0;
      span_q.zero <= 1'b0;
    end else begin
      state_q <= state_d;
      span_q  <= span_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = state_q != S_IDLE;
  assign span_o = span_q;

endmodule

// File: rtl/tiam_div_pipe.sv
// Restoring division pipeline: one quotient bit per stage for row and column
// against their spans. Depends on tiam_pkg.
module tiam_div_pipe
  import tiam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tiam_div_t        in_data_i,
  input  logic [DIM_W-1:0] row_span_i,
  input  logic [DIM_W-1:0] col_span_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tiam_div_t        out_data_o
);

  localparam int unsigned NSTG = COORD_W;

  typedef struct packed {
    logic               q;
    logic [COORD_W-1:0] r;
  } step_t;

  function automatic step_t div_step(logic [COORD_W-1:0] rem, logic b,
                                     logic [DIM_W-1:0] span);
    logic [DIM_W-1:0] sh;
    step_t            res;
    sh = {rem, b};
    if (sh >= span) begin
      res.q = 1'b1;
      res.r = COORD_W'(sh - span);
    end else begin
      res.q = 1'b0;
      res.r = sh[COORD_W-1:0];
    end
    return res;
  endfunction

  tiam_div_t stg_q [NSTG];
  tiam_div_t stg_d [NSTG];
  logic      vld_q [NSTG];
  logic      rdy   [NSTG+1];

  assign rdy[NSTG] = out_ready_i;

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    tiam_div_t src;
    logic      src_vld;
    step_t     rs, cs;

    if (k == 0) begin : g_first
      assign src     = in_data_i;
      assign src_vld = in_valid_i;
    end else begin : g_next
      assign src     = stg_q[k-1];
      assign src_vld = vld_q[k-1];
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];
    assign rs = div_step(src.rr, src.row[NSTG-1-k], row_span_i);
    assign cs = div_step(src.cr, src.col[NSTG-1-k], col_span_i);

    always_comb begin
      stg_d[k]              = src;
      stg_d[k].rq[NSTG-1-k] = rs.q;
      stg_d[k].cq[NSTG-1-k] = cs.q;
      stg_d[k].rr           = rs.r;
      stg_d[k].cr           = cs.r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_vld) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign out_data_o  = stg_q[NSTG-1];

endmodule

// File: rtl/tiam_post.sv
// Last two stages: tile clamping and inner position, then raster index and
// output packing into the output register. Depends on tiam_pkg.
module tiam_post
  import tiam_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  tiam_div_t              in_data_i,
  input  logic [FAC_W-1:0]       fac_i,
  input  tiam_span_t             row_sp_i,
  input  tiam_span_t             col_sp_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_tdata_o,
  output logic                   out_tuser_o
);

  typedef struct packed {
    logic [FAC_W-1:0]   t;
    logic [COORD_W-1:0] inner;
  } axis_t;

  typedef struct packed {
    logic               oor;
    axis_t              r;
    axis_t              c;
    logic [PIX_W-1:0]   val;
  } mid_t;

  function automatic axis_t locate(logic [COORD_W-1:0] q, logic [COORD_W-1:0] rem,
                                   logic [COORD_W-1:0] coord, tiam_span_t sp,
                                   logic [FAC_W-1:0] fm1);
    axis_t res;
    if (sp.zero) begin
      res.t     = fm1;
      res.inner = coord;
    end else if (q > COORD_W'(fm1)) begin
      // last tile takes the remainder
      res.t     = fm1;
      res.inner = COORD_W'(DIM_W'(coord) - sp.base);
    end else begin
      res.t     = FAC_W'(q);
      res.inner = rem;
    end
    return res;
  endfunction

  logic [FAC_W-1:0]       fm1;
  mid_t                   mid_q, mid_d;
  logic                   mid_vld_q;
  logic                   mid_rdy;
  logic                   out_vld_q;
  logic                   out_rdy;
  logic [OUT_TDATA_W-1:0] tdata_q, tdata_d;
  logic                   tuser_q;
  logic [2*FAC_W-1:0]     prod;
  logic [PIX_W-1:0]       pix_mask;

  assign fm1      = fac_i - 1'b1;
  assign pix_mask = ~({PIX_W{1'b1}} << PIXEL_BITS);

  always_comb begin
    mid_d.oor = in_data_i.oor;
    mid_d.r   = locate(in_data_i.rq, in_data_i.rr, in_data_i.row, row_sp_i, fm1);
    mid_d.c   = locate(in_data_i.cq, in_data_i.cr, in_data_i.col, col_sp_i, fm1);
    mid_d.val = in_data_i.val;
  end

  assign out_rdy    = !out_vld_q || out_ready_i;
  assign mid_rdy    = !mid_vld_q || out_rdy;
  assign in_ready_o = mid_rdy;

  assign prod = mid_q.r.t * fac_i;

  always_comb begin
    tdata_d = '0;
    if (!mid_q.oor) begin
      tdata_d = {mid_q.val & pix_mask,
                 mid_q.c.inner,
                 mid_q.r.inner,
                 TIDX_W'(prod + (2*FAC_W)'(mid_q.c.t)),
                 mid_q.c.t[TILE_W-1:0],
                 mid_q.r.t[TILE_W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (mid_rdy) begin
        mid_vld_q <= in_valid_i;
      end
      if (out_rdy) begin
        out_vld_q <= mid_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_rdy && in_valid_i) begin
      mid_q <= mid_d;
    end
    if (out_rdy && mid_vld_q) begin
      tdata_q <= tdata_d;
      tuser_q <= mid_q.oor;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_tdata_o = tdata_q;
  assign out_tuser_o = tuser_q;

endmodule

// File: rtl/image_tile_address_mapper_top.sv
// Top level of the image tile address mapper: configuration registers, span
// dividers, division pipeline and output stages. Depends on tiam_pkg.
//
// Usage: pixel words (row, column, gray value) enter on the s_axis stream and
// leave on the m_axis stream as tile row/column, raster tile index, position
// inside the tile and the gray value; tuser flags a pixel outside the image,
// in which case all tdata fields are zero.
// Between the input handshake and the output a word passes 12 division stages
// (one quotient bit each), a clamp stage and the output register, which drives
// m_axis_tvalid.
// Throughput is one word per clock while m_axis_tready is high and no span
// recompute runs; nothing is held between words. A configuration write starts
// two per-axis span dividers (dim / factor, one bit a cycle, then the last-tile
// base); s_axis_tready stays low after the last write while they run.
// Reset sets width, height and factor to 1 and empties the pipeline.
// When m_axis_tready is low the pipeline fills its empty stages and then holds;
// s_axis_tready drops once every stage is occupied. No word is lost or doubled.
module image_tile_address_mapper_top
  import tiam_pkg::*;
#(
  parameter int unsigned MAX_DIM    = DEF_MAX_DIM,
  parameter int unsigned MAX_FACTOR = DEF_MAX_FACTOR,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DIM_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pixel_row[11:0], pixel_col[23:12], pixel_value[39:24]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tile_row[5:0], tile_col[11:6], tile_index[23:12], inner_row[35:24],
  // inner_col[47:36], gray_out[63:48]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // out_of_range[0]
  output logic                   m_axis_tuser
);

  logic [DIM_W-1:0] width_q, height_q;
  logic [FAC_W-1:0] factor_q;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [FAC_W-1:0] f_eff;
  logic             start_q;
  logic             row_busy, col_busy, busy;
  tiam_span_t       row_sp, col_sp;
  tiam_div_t        pix;
  logic             pipe_rdy;
  logic             div_vld, div_rdy;
  tiam_div_t        div_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      factor_q <= FAC_W'(1);
      start_q  <= 1'b0;
    end else begin
      start_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          REG_FACTOR: factor_q <= cfg_data_i[FAC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    w_eff = (32'(width_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_q;
    h_eff = (32'(height_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_q;
    if (factor_q == '0) begin
      f_eff = FAC_W'(1);
    end else if (32'(factor_q) > 32'(MAX_FACTOR)) begin
      f_eff = FAC_W'(MAX_FACTOR);
    end else begin
      f_eff = factor_q;
    end
  end

  tiam_span_div u_row_span (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .dim_i   (h_eff),
    .fac_i   (f_eff),
    .busy_o  (row_busy),
    .span_o  (row_sp)
  );

  tiam_span_div u_col_span (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .dim_i   (w_eff),
    .fac_i   (f_eff),
    .busy_o  (col_busy),
    .span_o  (col_sp)
  );

  assign busy = start_q || row_busy || col_busy;

  always_comb begin
    pix.row = s_axis_tdata[COORD_W-1:0];
    pix.col = s_axis_tdata[2*COORD_W-1:COORD_W];
    pix.val = s_axis_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
    pix.oor = (DIM_W'(pix.row) >= h_eff) || (DIM_W'(pix.col) >= w_eff);
    pix.rq  = '0;
    pix.cq  = '0;
    pix.rr  = '0;
    pix.cr  = '0;
  end

  assign s_axis_tready = pipe_rdy && !busy;

  tiam_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && !busy),
    .in_ready_o  (pipe_rdy),
    .in_data_i   (pix),
    .row_span_i  (row_sp.span),
    .col_span_i  (col_sp.span),
    .out_valid_o (div_vld),
    .out_ready_i (div_rdy),
    .out_data_o  (div_data)
  );

  tiam_post #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_vld),
    .in_ready_o  (div_rdy),
    .in_data_i   (div_data),
    .fac_i       (f_eff),
    .row_sp_i    (row_sp),
    .col_sp_i    (col_sp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

  // span recompute blocks the input
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("input accepted while spans recompute");

  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input accepted right after a configuration write");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("out-of-range word carries nonzero fields");

endmodule
